>>> design/assert_macros.svh
// Assertion macros shared by the nearest palette color RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define NPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define NPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define NPC_ASSERT(lbl, clk, rstn, prop, msg)
`define NPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/npc_pkg.sv
// Shared constants and types of the nearest palette color block.
// Used by npc_dist and nearest_palette_color; depends on nothing else.
`default_nettype none

package npc_pkg;

  // Palette geometry.
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

  // Color component and packed color widths.
  localparam int COMP_W  = 8;
  localparam int COLOR_W = 3 * COMP_W;

  // Three squared 8-bit differences sum to at most 195075, which fits in 18 bits.
  localparam int DIST_W = 2 * COMP_W + 2;

  // The search starts above every reachable distance, so the first entry always wins.
  localparam logic [DIST_W-1:0] BEST_START = {DIST_W{1'b1}};

  // Request kinds carried on tuser.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MAP   = 1'b1;

  // Configuration register map.
  localparam int               APB_AW   = 3;
  localparam logic             REG_MODE = 1'b0;  // paddr[2] of the mode register

  // Tag that travels alongside an entry through the distance unit.
  typedef struct packed {
    logic              vld;
    logic [PAL_AW-1:0] idx;
  } dist_tag_t;

endpackage

`default_nettype wire

>>> design/npc_dist.sv
// Registered squared Euclidean RGB distance unit, shared by every step of a scan.
// Depends on npc_pkg for widths and the tag type.
`default_nettype none

module npc_dist
  import npc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dist_tag_t          tag_i,
  input  wire logic [COLOR_W-1:0] entry_i,   // red [7:0], green [15:8], blue [23:16]
  input  wire logic [COMP_W-1:0]  red_i,
  input  wire logic [COMP_W-1:0]  green_i,
  input  wire logic [COMP_W-1:0]  blue_i,
  output dist_tag_t               tag_o,
  output logic [DIST_W-1:0]       dist_o
);

  logic [COMP_W-1:0]   e_red, e_green, e_blue;
  logic [COMP_W-1:0]   d_red, d_green, d_blue;
  logic [2*COMP_W-1:0] sq_red, sq_green, sq_blue;
  logic [DIST_W-1:0]   dist_d, dist_q;
  dist_tag_t           tag_q;

  // Unpack the stored entry.
  assign e_red   = entry_i[COMP_W-1:0];
  assign e_green = entry_i[2*COMP_W-1:COMP_W];
  assign e_blue  = entry_i[3*COMP_W-1:2*COMP_W];

  // Absolute component differences, then their squares and sum.
  always_comb begin
    d_red    = (e_red   > red_i)   ? (e_red   - red_i)   : (red_i   - e_red);
    d_green  = (e_green > green_i) ? (e_green - green_i) : (green_i - e_green);
    d_blue   = (e_blue  > blue_i)  ? (e_blue  - blue_i)  : (blue_i  - e_blue);
    sq_red   = d_red   * d_red;
    sq_green = d_green * d_green;
    sq_blue  = d_blue  * d_blue;
    dist_d   = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  end

  // The tag valid bit is control; the distance is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign tag_o  = tag_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

>>> design/nearest_palette_color.sv
// Top level of the nearest palette color block: ports, palette memory and scan sequencer.
// Depends on npc_pkg, npc_dist and assert_macros.svh.
//
//   channel   | direction | tdata / tuser contents (lowest bit first)
//   ----------+-----------+--------------------------------------------------------
//   s_axis    | in        | tdata: entry_index, red, green, blue; tuser: kind
//   m_axis    | out       | tdata: mapped (24 bits)
//   apb       | in/out    | byte 0: indexed_mode in bit 0
//
// A palette write request is stored at the edge that accepts it. A direct-mode query
// packs its color into the result register. An indexed query runs the colors in use
// through the read register and the single distance unit, one palette entry per cycle.
// Reset clears every valid bit of the palette at once, so no clearing pass is needed.
// A finished result waits in the output register; the input side stays open meanwhile,
// but stays closed from the acceptance of a query until its result enters that register.
`default_nettype none
`include "assert_macros.svh"

module nearest_palette_color
  import npc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // entry_index, red, green, blue
  input  wire logic [0:0]        s_axis_tuser,   // kind
  // Result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [23:0]            m_axis_tdata,   // mapped
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic                     mode_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         issue_q, issue_d;
  logic [PALETTE_ENTRIES-1:0] valid_q;
  logic [COLOR_W-1:0]       mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0]       rd_data_q;
  logic                     rd_vld_q;
  logic [COLOR_W-1:0]       entry;
  logic [COMP_W-1:0]        q_red_q, q_green_q, q_blue_q;
  logic [COLOR_W-1:0]       res_q, res_d;
  logic [DIST_W-1:0]        best_d_q;
  logic [PAL_AW-1:0]        best_idx_q;
  logic                     m_tvalid_q, m_tvalid_d;
  logic [COLOR_W-1:0]       m_tdata_q;
  dist_tag_t                rd_tag_q, d_tag;
  logic [DIST_W-1:0]        d_dist;

  logic                     in_fire, wr_fire, map_fire, cfg_wr;
  logic                     issue_fire, best_upd, out_load, scan_done;
  logic                     wr_in_range;
  logic [CNT_W-1:0]         wr_count;
  logic [COMP_W-1:0]        in_idx, in_red, in_green, in_blue;

  // Unpack the request.
  assign in_idx   = s_axis_tdata[7:0];
  assign in_red   = s_axis_tdata[15:8];
  assign in_green = s_axis_tdata[23:16];
  assign in_blue  = s_axis_tdata[31:24];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wr_fire       = in_fire && (s_axis_tuser[0] == KIND_WRITE);
  assign map_fire      = in_fire && (s_axis_tuser[0] == KIND_MAP);

  // A write beyond the palette is dropped.
  assign wr_in_range = ({1'b0, in_idx} < 9'(PALETTE_ENTRIES));
  assign wr_count    = CNT_W'({1'b0, in_idx} + 9'd1);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

  // Scan control.
  assign issue_fire = (state_q == ST_SCAN) && (issue_q < count_q);
  assign scan_done  = (state_q == ST_SCAN) && (issue_q == count_q)
                      && !rd_tag_q.vld && !d_tag.vld;
  assign best_upd   = d_tag.vld && (d_dist < best_d_q);
  assign out_load   = (state_q == ST_FIN) && (!m_tvalid_q || m_axis_tready);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (map_fire) begin
          issue_d = '0;
          if (mode_q) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
            res_d   = {in_blue, in_green, in_red};
          end
        end
      end
      ST_SCAN: begin
        if (issue_fire) begin
          issue_d = issue_q + 1'b1;
        end
        if (scan_done) begin
          state_d = ST_FIN;
          res_d   = COLOR_W'(best_idx_q);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issue_q    <= '0;
      mode_q     <= 1'b1;
      count_q    <= CNT_W'(PALETTE_ENTRIES);
      valid_q    <= '0;
      rd_tag_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      m_tvalid_q <= m_tvalid_d;
      rd_tag_q.vld <= issue_fire;
      rd_tag_q.idx <= issue_q[PAL_AW-1:0];
      if (cfg_wr) begin
        mode_q <= pwdata[0];
      end
      if (wr_fire && wr_in_range) begin
        valid_q[in_idx[PAL_AW-1:0]] <= 1'b1;
        if (count_q < wr_count) begin
          count_q <= wr_count;
        end
      end
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_fire && wr_in_range) begin
      mem[in_idx[PAL_AW-1:0]] <= {in_blue, in_green, in_red};
    end
    if (issue_fire) begin
      rd_data_q <= mem[issue_q[PAL_AW-1:0]];
      rd_vld_q  <= valid_q[issue_q[PAL_AW-1:0]];
    end
  end

  // An entry never written reads as black.
  assign entry = rd_vld_q ? rd_data_q : '0;

  npc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .entry_i (entry),
    .red_i   (q_red_q),
    .green_i (q_green_q),
    .blue_i  (q_blue_q),
    .tag_o   (d_tag),
    .dist_o  (d_dist)
  );

  // Query color, running best and result payload.
  always_ff @(posedge clk_i) begin
    if (map_fire) begin
      q_red_q    <= in_red;
      q_green_q  <= in_green;
      q_blue_q   <= in_blue;
      best_d_q   <= BEST_START;
      best_idx_q <= '0;
    end else if (best_upd) begin
      best_d_q   <= d_dist;
      best_idx_q <= d_tag.idx;
    end
    res_q <= res_d;
    if (out_load) begin
      m_tdata_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // Checks on the scan sequencer.
  `NPC_ASSERT(a_issue_bound, clk_i, rst_ni, (state_q != ST_SCAN) || (issue_q <= count_q), "scan issued past colors in use")
  `NPC_ASSERT(a_drain_first, clk_i, rst_ni, !((state_q == ST_SCAN) && (state_d == ST_FIN)) || (!rd_tag_q.vld && !d_tag.vld), "scan ended with entries in flight")
  `NPC_ASSERT_NEXT(a_count_grows, clk_i, rst_ni, 1'b1, count_q >= $past(count_q), "colors in use decreased")
  `NPC_ASSERT_NEXT(a_best_falls, clk_i, rst_ni, best_upd && !map_fire, best_d_q < $past(best_d_q), "best distance did not improve")

endmodule

`default_nettype wire

>>> test/nearest_palette_color_tb.sv
// Self-checking testbench for the nearest palette color block.
// Drives palette writes and color queries over the request stream, checks each result
// against an in-bench palette model; depends on npc_pkg and the nearest_palette_color RTL.
`default_nettype none

module nearest_palette_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int               IDLE_LIMIT    = 4000;
  localparam int               SETTLE_CYCLES = 8;
  localparam int               TAIL_CYCLES   = PALETTE_ENTRIES + 40;
  localparam int               MAX_PRINTED   = 50;
  localparam int               PHASE_ITEMS   = 170;
  localparam int unsigned      FAR_DIST      = 32'h7fffffff;
  localparam logic [APB_AW-1:0] MODE_ADDR    = '0;
  localparam logic             MODE_DIRECT   = 1'b0;
  localparam logic             MODE_INDEXED  = 1'b1;

  // Block inputs start at known values.
  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic [31:0]       s_axis_tdata  = '0;   // entry_index, red, green, blue
  logic [0:0]        s_axis_tuser  = '0;   // kind
  logic              m_axis_tready = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;

  wire logic         s_axis_tready;
  wire logic         m_axis_tvalid;
  wire logic [23:0]  m_axis_tdata;    // mapped
  wire logic [31:0]  prdata;
  wire logic         pready;

  // Palette model: store, count of colors in use and the mode register.
  logic [23:0]       shadow_palette [PALETTE_ENTRIES];
  logic [CNT_W-1:0]  shadow_in_use;
  logic              shadow_indexed;
  logic [23:0]       expected_mapped_q [$];

  int error_count     = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  bit sender_idles    = 1'b1;
  int writes_seen     = 0;
  int indexed_queries = 0;
  int direct_queries  = 0;
  int results_checked = 0;
  int rx_left         = 0;
  bit rx_ready_phase  = 1'b0;

  nearest_palette_color dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Prints the first few mismatches and counts all of them.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Scans the colors in use for the least squared distance; the lowest index wins a tie.
  function automatic logic [23:0] nearest_entry(input logic [7:0] r, g, b);
    int unsigned best_d;
    int unsigned d;
    int          dr, dg, db;
    logic [23:0] best;
    best_d = FAR_DIST;
    best   = '0;
    for (int i = 0; i < PALETTE_ENTRIES && i < int'(shadow_in_use); i++) begin
      dr = int'(shadow_palette[i][7:0])   - int'(r);
      dg = int'(shadow_palette[i][15:8])  - int'(g);
      db = int'(shadow_palette[i][23:16]) - int'(b);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best   = 24'(i);
      end
    end
    return best;
  endfunction

  // Applies one accepted request to the palette model and queues its result.
  task automatic predict_request(input logic kind, input logic [31:0] data);
    logic [7:0] idx, r, g, b;
    idx = data[7:0];
    r   = data[15:8];
    g   = data[23:16];
    b   = data[31:24];
    if (kind == KIND_WRITE) begin
      writes_seen++;
      if (int'(idx) < PALETTE_ENTRIES) begin
        shadow_palette[idx] = {b, g, r};
        if (shadow_in_use < {1'b0, idx} + 1'b1) shadow_in_use = {1'b0, idx} + 1'b1;
      end
    end else if (shadow_indexed) begin
      indexed_queries++;
      expected_mapped_q.push_back(nearest_entry(r, g, b));
    end else begin
      direct_queries++;
      expected_mapped_q.push_back({b, g, r});
    end
  endtask

  // Checks each result against the oldest expectation, then tracks accepted requests.
  always @(posedge clk_i) begin : result_checker
    logic [23:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (expected_mapped_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no query waiting", m_axis_tdata));
        end else begin
          want = expected_mapped_q.pop_front();
          if (m_axis_tdata !== want) begin
            report_mismatch($sformatf("mapped %h, expected %h", m_axis_tdata, want));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser[0], s_axis_tdata);
    end
  end

  // Receiver alternates ready and stall stretches, now and then a long ready one.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_ready_phase = !rx_ready_phase;
      if (rx_ready_phase) begin
        rx_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 30);
      end else begin
        rx_left = $urandom_range(1, 12);
      end
    end
    rx_left--;
    m_axis_tready <= rx_ready_phase;
  end

  // Counts cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog ends a stuck run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("[%0t] timeout: no activity for %0d cycles", $realtime, IDLE_LIMIT);
    $display("nearest_palette_color_tb: errors");
    $finish;
  end

  // Sends one request; the sender works in bursts with random gaps between them.
  task automatic send_request(input logic kind, input logic [7:0] idx, r, g, b);
    int gap;
    if (burst_left <= 0) begin
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {b, g, r, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    // The checker queues the request accepted at this edge during the same step.
    @(posedge clk_i);
    while (expected_mapped_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the mode register while the block is idle, then reads it back.
  task automatic write_mode(input logic mode);
    logic [31:0] readback;
    drain_results();
    // A trailing palette write may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'b0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_indexed = mode;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[0] !== mode) begin
      report_mismatch($sformatf("mode register reads %h, expected %0b", readback, mode));
    end
  endtask

  // After reset every entry is black and all are in use, so any query maps to index 0.
  task automatic test_black_palette();
    send_request(KIND_MAP, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(KIND_MAP, 8'hff, 8'hff, 8'hff, 8'hff);
    send_request(KIND_MAP, 8'h5a, 8'h80, 8'h01, 8'hfe);
  endtask

  // Primary colors, white, gray and a duplicate entry to exercise the tie rule.
  task automatic test_entries_and_ties();
    send_request(KIND_WRITE, 8'd1,   8'hff, 8'h00, 8'h00);
    send_request(KIND_WRITE, 8'd2,   8'h00, 8'hff, 8'h00);
    send_request(KIND_WRITE, 8'd3,   8'h00, 8'h00, 8'hff);
    send_request(KIND_WRITE, 8'd4,   8'hff, 8'h00, 8'h00);
    send_request(KIND_WRITE, 8'd255, 8'hff, 8'hff, 8'hff);
    send_request(KIND_WRITE, 8'd128, 8'h80, 8'h80, 8'h80);
    send_request(KIND_MAP,   8'h00,  8'hff, 8'hff, 8'hff);
    send_request(KIND_MAP,   8'h00,  8'hfa, 8'h03, 8'h03);
    send_request(KIND_MAP,   8'h00,  8'h00, 8'hff, 8'h00);
    send_request(KIND_MAP,   8'h00,  8'h00, 8'h00, 8'hfe);
    send_request(KIND_MAP,   8'h00,  8'h80, 8'h7f, 8'h81);
    send_request(KIND_MAP,   8'hff,  8'h00, 8'h00, 8'h00);
    send_request(KIND_MAP,   8'h33,  8'h40, 8'h40, 8'h40);
  endtask

  // Direct mode packs the color; palette writes made meanwhile still take effect.
  task automatic test_direct_packing();
    write_mode(MODE_DIRECT);
    send_request(KIND_MAP,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(KIND_MAP,   8'hff, 8'hff, 8'hff, 8'hff);
    send_request(KIND_MAP,   8'h00, 8'h12, 8'h34, 8'h56);
    send_request(KIND_WRITE, 8'd77, 8'd17, 8'd99, 8'd201);
    write_mode(MODE_INDEXED);
    send_request(KIND_MAP,   8'h00, 8'd17, 8'd99, 8'd201);
    send_request(KIND_MAP,   8'h00, 8'd18, 8'd98, 8'd200);
  endtask

  // One random request: writes, duplicated entries, and queries that are random,
  // close to a stored entry, or at the corners of the color cube.
  task automatic random_request();
    logic [7:0]  idx, r, g, b;
    logic [23:0] entry;
    int          roll;
    idx   = 8'($urandom);
    r     = 8'($urandom);
    g     = 8'($urandom);
    b     = 8'($urandom);
    entry = shadow_palette[$urandom_range(0, PALETTE_ENTRIES - 1)];
    roll  = $urandom_range(0, 99);
    if (roll < 35) begin
      send_request(KIND_WRITE, idx, r, g, b);
    end else if (roll < 42) begin
      send_request(KIND_WRITE, idx, entry[7:0], entry[15:8], entry[23:16]);
    end else if (roll < 65) begin
      send_request(KIND_MAP, idx, r, g, b);
    end else if (roll < 85) begin
      r = entry[7:0]   + 8'($urandom_range(0, 6)) - 8'd3;
      g = entry[15:8]  + 8'($urandom_range(0, 6)) - 8'd3;
      b = entry[23:16] + 8'($urandom_range(0, 6)) - 8'd3;
      send_request(KIND_MAP, idx, r, g, b);
    end else begin
      r = $urandom_range(0, 1) ? 8'hff : 8'h00;
      g = $urandom_range(0, 1) ? 8'hff : 8'h00;
      b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      send_request(KIND_MAP, idx, r, g, b);
    end
  endtask

  // Random traffic in phases that switch the mode; one phase runs without sender gaps
  // and one pauses until all results are back.
  task automatic test_random_traffic();
    logic phase_mode [6];
    phase_mode = '{MODE_INDEXED, MODE_DIRECT, MODE_INDEXED, MODE_DIRECT,
                   MODE_INDEXED, MODE_INDEXED};
    for (int p = 0; p < 6; p++) begin
      write_mode(phase_mode[p]);
      sender_idles = (p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
        random_request();
      end
    end
    sender_idles = 1'b1;
  endtask

  // Test sequence.
  initial begin
    shadow_in_use  = CNT_W'(PALETTE_ENTRIES);
    shadow_indexed = MODE_INDEXED;
    for (int i = 0; i < PALETTE_ENTRIES; i++) shadow_palette[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_black_palette();
    test_entries_and_ties();
    test_direct_packing();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d palette writes, %0d indexed and %0d direct queries;",
             writes_seen, indexed_queries, direct_queries);
    $display("checked %0d results across both modes, %0d mismatches.",
             results_checked, error_count);
    if (error_count == 0 && expected_mapped_q.size() == 0) begin
      $display("nearest_palette_color_tb: clean");
    end else begin
      $display("nearest_palette_color_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+design
design/npc_pkg.sv
design/npc_dist.sv
design/nearest_palette_color.sv
test/nearest_palette_color_tb.sv
